// File: sv/dfi_pkg.sv
// Shared types, widths and register indexes for the direct form I IIR filter.
package dfi_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int FRAC_W    = 28;
    localparam int NUM_FF    = 4;
    localparam int NUM_FB    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int RES_W     = ACC_W - FRAC_W;

    localparam int FF_TAPS_DEF = 4;
    localparam int FB_TAPS_DEF = 3;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [COEF_W-1:0]    coef_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_FF_COEF_0 = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FF_COEF_1 = cfg_idx_t'(1);
    localparam cfg_idx_t REG_FF_COEF_2 = cfg_idx_t'(2);
    localparam cfg_idx_t REG_FF_COEF_3 = cfg_idx_t'(3);
    localparam cfg_idx_t REG_FB_COEF_1 = cfg_idx_t'(4);
    localparam cfg_idx_t REG_FB_COEF_2 = cfg_idx_t'(5);
    localparam cfg_idx_t REG_FB_COEF_3 = cfg_idx_t'(6);

    // Unity gain in Q4.28.
    localparam coef_t FF_COEF_0_RESET = 32'sh1000_0000;

    // fb[0] is the coefficient of y[n-1].
    typedef struct packed {
        coef_t [NUM_FF-1:0] ff;
        coef_t [NUM_FB-1:0] fb;
    } coef_bank_t;

    typedef struct packed {
        sample_t value;
        logic    sat;
    } mac_result_t;

endpackage

// File: sv/dfi_coef_bank.sv
// Coefficient register bank written through the configuration port.
module dfi_coef_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  dfi_pkg::cfg_idx_t   cfg_index,
    input  dfi_pkg::coef_t      cfg_data,
    output dfi_pkg::coef_bank_t coefs
);
    import dfi_pkg::*;

    // Unity gain on the current input, every other tap zero.
    localparam coef_bank_t COEF_RESET = coef_bank_t'({{(NUM_FF-1){COEF_W'(0)}},
                                                      FF_COEF_0_RESET,
                                                      {NUM_FB{COEF_W'(0)}}});

    coef_bank_t coefs_reg;
    coef_bank_t coefs_next;

    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FF_COEF_0: coefs_next.ff[0] = cfg_data;
                REG_FF_COEF_1: coefs_next.ff[1] = cfg_data;
                REG_FF_COEF_2: coefs_next.ff[2] = cfg_data;
                REG_FF_COEF_3: coefs_next.ff[3] = cfg_data;
                REG_FB_COEF_1: coefs_next.fb[0] = cfg_data;
                REG_FB_COEF_2: coefs_next.fb[1] = cfg_data;
                REG_FB_COEF_3: coefs_next.fb[2] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= COEF_RESET;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// File: sv/dfi_mac.sv
// Tap products, exact sum, round to nearest and saturation to the sample width.
module dfi_mac #(
    parameter int FF_TAPS = dfi_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS = dfi_pkg::FB_TAPS_DEF
) (
    input  dfi_pkg::coef_bank_t                    coefs,
    input  dfi_pkg::sample_t                       x_cur,
    input  dfi_pkg::sample_t [dfi_pkg::NUM_FF-2:0] x_hist,
    input  dfi_pkg::sample_t [dfi_pkg::NUM_FB-1:0] y_hist,
    output dfi_pkg::mac_result_t                   result
);
    import dfi_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_BIAS =
        {{(ACC_W-FRAC_W+1){1'b0}}, {(FRAC_W-1){1'b0}}} | (ACC_W'(1) << (FRAC_W-1));
    localparam logic signed [RES_W-1:0] SAT_MAX =
        {{(RES_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN =
        {{(RES_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    sample_t [NUM_FF-1:0]          x_taps;
    logic signed [PROD_W-1:0]      ff_prod [NUM_FF];
    logic signed [PROD_W-1:0]      fb_prod [NUM_FB];
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       rounded;
    logic signed [RES_W-1:0]       shifted;

    assign x_taps = {x_hist, x_cur};

    for (genvar k = 0; k < NUM_FF; k++) begin : g_ff
        if (k < FF_TAPS) begin : g_used
            assign ff_prod[k] = $signed(coefs.ff[k]) * $signed(x_taps[k]);
        end else begin : g_unused
            assign ff_prod[k] = '0;
        end
    end

    for (genvar k = 0; k < NUM_FB; k++) begin : g_fb
        if (k < FB_TAPS) begin : g_used
            assign fb_prod[k] = $signed(coefs.fb[k]) * $signed(y_hist[k]);
        end else begin : g_unused
            assign fb_prod[k] = '0;
        end
    end

    always_comb begin
        acc = '0;
        for (int k = 0; k < NUM_FF; k++) begin
            acc = acc + ACC_W'(ff_prod[k]);
        end
        for (int k = 0; k < NUM_FB; k++) begin
            acc = acc - ACC_W'(fb_prod[k]);
        end
        // Taking the upper bits is a floor shift, so ties round upward.
        rounded = acc + RND_BIAS;
        shifted = $signed(rounded[ACC_W-1:FRAC_W]);
    end

    always_comb begin
        if (shifted > SAT_MAX) begin
            result.value = SAT_MAX[SAMPLE_W-1:0];
            result.sat   = 1'b1;
        end else if (shifted < SAT_MIN) begin
            result.value = SAT_MIN[SAMPLE_W-1:0];
            result.sat   = 1'b1;
        end else begin
            result.value = shifted[SAMPLE_W-1:0];
            result.sat   = 1'b0;
        end
    end

endmodule

// File: sv/direct_form_iir_filter.sv
// Top level of the direct form I IIR filter with stream ports.
//
//  Channel  | Direction | Transfer when          | Contents
//  ---------+-----------+------------------------+------------------------------------
//  s_       | in        | s_tvalid && s_tready   | tdata: sample_in, tuser: first flag
//  m_       | out       | m_tvalid && m_tready   | tdata: sample_out, tuser: saturated
//  cfg_     | in        | cfg_we                 | coefficient index and value
//
// One sample is taken per clock cycle unless m_tready stalls the output. A sample
// accepted into the input register has its result loaded into the output register
// as soon as that register is free or being emptied; m_tvalid then goes high. The
// feedback loop through the output history (seven multiplies, the sum, rounding
// and clipping) has no register but the history and sets the clock rate. Reset is
// synchronous and active low; it empties both registers, clears the histories and
// loads the default coefficients. A stall on m_tready holds the output; the input
// register still takes one more sample, after which s_tready follows m_tready.
module direct_form_iir_filter #(
    parameter int FF_TAPS = dfi_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS = dfi_pkg::FB_TAPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dfi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfi_pkg::COEF_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // [23:0] sample_in
    input  logic [0:0]                    s_tuser,   // [0] first_of_signal
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [23:0] sample_out
    output logic [0:0]                    m_tuser    // [0] saturated
);
    import dfi_pkg::*;

    coef_bank_t  coefs;
    mac_result_t mac_result;

    // Input register: one accepted sample waiting for the filter pass.
    logic    in_valid_reg, in_valid_next;
    sample_t in_sample_reg, in_sample_next;
    logic    in_first_reg, in_first_next;

    // Output register: the result waiting for its transfer.
    logic    out_valid_reg, out_valid_next;
    sample_t out_sample_reg, out_sample_next;
    logic    out_sat_reg, out_sat_next;

    // Histories, newest entry at index zero.
    sample_t [NUM_FF-2:0] x_hist_reg, x_hist_next;
    sample_t [NUM_FB-1:0] y_hist_reg, y_hist_next;
    sample_t [NUM_FF-2:0] x_hist_eff;
    sample_t [NUM_FB-1:0] y_hist_eff;

    logic advance;
    logic s_accept;

    dfi_coef_bank u_coef_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (coef_t'(cfg_data)),
        .coefs     (coefs)
    );

    // A start-of-signal sample sees zero histories, exactly as after reset.
    assign x_hist_eff = in_first_reg ? '0 : x_hist_reg;
    assign y_hist_eff = in_first_reg ? '0 : y_hist_reg;

    dfi_mac #(
        .FF_TAPS (FF_TAPS),
        .FB_TAPS (FB_TAPS)
    ) u_mac (
        .coefs  (coefs),
        .x_cur  (in_sample_reg),
        .x_hist (x_hist_eff),
        .y_hist (y_hist_eff),
        .result (mac_result)
    );

    // The held sample moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_sample_next  = in_sample_reg;
        in_first_next   = in_first_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_sat_next    = out_sat_reg;
        x_hist_next     = x_hist_reg;
        y_hist_next     = y_hist_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (advance) begin
            in_valid_next   = 1'b0;
            out_valid_next  = 1'b1;
            out_sample_next = mac_result.value;
            out_sat_next    = mac_result.sat;
            // The clipped result is what enters the output history.
            x_hist_next     = {x_hist_eff[NUM_FF-3:0], in_sample_reg};
            y_hist_next     = {y_hist_eff[NUM_FB-2:0], mac_result.value};
        end

        if (s_accept) begin
            in_valid_next  = 1'b1;
            in_sample_next = sample_t'(s_tdata);
            in_first_next  = s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_hist_reg    <= '0;
            y_hist_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            x_hist_reg    <= x_hist_next;
            y_hist_reg    <= y_hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_sample_reg  <= in_sample_next;
        in_first_reg   <= in_first_next;
        out_sample_reg <= out_sample_next;
        out_sat_reg    <= out_sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// File: sv/dfi_checker.sv
// Port-level checks for the direct form I IIR filter, bound to the top level.
module dfi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A result waiting for its transfer stays offered.
    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value and flag.
    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A clipped result sits at one of the two range limits.
    a_sat_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 24'h7FFFFF || m_tdata == 24'h800000))
        else $error("saturation flag on a value inside the range");

    // With the output register empty the input side is never held off.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // A rise of m_tvalid must be preceded by the input transfer that caused it, which
    // passed through the input register before its result reached the output register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind direct_form_iir_filter dfi_checker u_dfi_checker (.*);
